FILE: rtl/bgm_pkg.sv
// ----------------------------------------------------------------------------
// Battery gauge monitor package
// Shared constants, the discharge curve tables and the stage payload types.
// ----------------------------------------------------------------------------
package bgm_pkg;

    localparam int WINDOW_DEPTH = 3;
    localparam int ADC_BITS     = 12;

    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = ADC_BITS + FILL_W;
    localparam int TICK_W = 8;

    // Division of the window sum by the fill count uses a reciprocal table.
    // With this many fraction bits the floor is exact for every possible sum.
    localparam int RECIP_FRAC  = SUM_W + 3;
    localparam int RECIP_W     = RECIP_FRAC + 1;
    localparam int RECIP_IDX_W = 4;
    localparam logic [RECIP_W-1:0] RECIP_TAB [0:8] = '{
        RECIP_W'(0),
        RECIP_W'((2 ** RECIP_FRAC) / 1),
        RECIP_W'((2 ** RECIP_FRAC + 1) / 2),
        RECIP_W'((2 ** RECIP_FRAC + 2) / 3),
        RECIP_W'((2 ** RECIP_FRAC + 3) / 4),
        RECIP_W'((2 ** RECIP_FRAC + 4) / 5),
        RECIP_W'((2 ** RECIP_FRAC + 5) / 6),
        RECIP_W'((2 ** RECIP_FRAC + 6) / 7),
        RECIP_W'((2 ** RECIP_FRAC + 7) / 8)
    };

    localparam int LEVEL_W = 7;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 7'd80;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 7'd100;
    localparam logic [LEVEL_W-1:0] LEVEL_EMPTY = 7'd0;

    // Seven-point discharge curve. Each segment slope is the percent step
    // over the converter span, scaled by 2^SLOPE_FRAC and rounded up, which
    // gives an exact floor for every offset inside the segment.
    localparam int CURVE_POINTS = 7;
    localparam int CURVE_W      = 16;
    localparam int SEG_W        = 3;
    localparam int DELTA_W      = 7;
    localparam int SLOPE_FRAC   = 20;
    localparam int SLOPE_W      = 19;
    localparam int CURVE_PROD_W = DELTA_W + SLOPE_W;

    localparam logic [CURVE_W-1:0] CURVE_ADC [0:CURVE_POINTS-1] = '{
        16'd1650, 16'd1750, 16'd1825, 16'd1900, 16'd1975, 16'd2050, 16'd2100
    };
    localparam logic [LEVEL_W-1:0] CURVE_PCT [0:CURVE_POINTS-1] = '{
        7'd0, 7'd10, 7'd20, 7'd40, 7'd60, 7'd80, 7'd100
    };
    localparam logic [SLOPE_W-1:0] CURVE_SLOPE [0:CURVE_POINTS-2] = '{
        SLOPE_W'((10 * 2 ** SLOPE_FRAC + 99) / 100),
        SLOPE_W'((10 * 2 ** SLOPE_FRAC + 74) / 75),
        SLOPE_W'((20 * 2 ** SLOPE_FRAC + 74) / 75),
        SLOPE_W'((20 * 2 ** SLOPE_FRAC + 74) / 75),
        SLOPE_W'((20 * 2 ** SLOPE_FRAC + 74) / 75),
        SLOPE_W'((20 * 2 ** SLOPE_FRAC + 49) / 50)
    };

    // Configuration registers.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_THRESHOLD   = 2'd0,
        CFG_SAMPLE_INTERVAL = 2'd1,
        CFG_SAMPLING_PAUSED = 2'd2
    } cfg_index_t;

    localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 7'd15;
    localparam logic [TICK_W-1:0]  INTERVAL_RESET  = 8'd60;

    // Per-request flags carried down the pipeline.
    typedef struct packed {
        logic charging;
        logic charge_ev;
        logic taken;
        logic full;
    } flags_t;

    typedef struct packed {
        flags_t             flags;
        logic [FILL_W-1:0]  fill;
        logic [SUM_W-1:0]   sum;
    } win_t;

    typedef struct packed {
        flags_t              flags;
        logic [ADC_BITS-1:0] avg;
    } avg_t;

    typedef struct packed {
        flags_t              flags;
        logic [ADC_BITS-1:0] avg;
        logic [LEVEL_W-1:0]  level;
    } lvl_t;

endpackage

FILE: rtl/battery_gauge_monitor_unit.sv
// ----------------------------------------------------------------------------
// Battery gauge monitor
// Tick-driven battery gauge with a moving-average window and a piecewise
// linear discharge curve, producing one status result per tick.
// ----------------------------------------------------------------------------
// Usage: every request on the s_ channel is one check tick carrying the
// charge-detect pin level (low means charging), a converter reading and a
// flag telling whether that reading is good. Each tick produces exactly one
// result on the m_ channel with the level in percent, the window average,
// the charge and low-battery flags and the change events of that tick.
// The three configuration registers (low threshold, sample interval and
// pause) are written through the cfg_ channel, which is always ready; they
// are meant to be changed only while no tick is in flight.
// Pipeline and throughput: a tick passes through four register stages
// (sampling control, window average, level curve, result register), and
// one tick can be accepted in every cycle unless the receiver stalls. The
// curve and average multiplies each own a stage.
// Reset: aresetn is synchronous and active low. It returns the registers to
// their defaults, empties the window and the pipeline, and sets the level to
// 80 percent. When the receiver stalls, results queue in the pipeline; the
// block keeps taking ticks until every stage holds one, then s_ready drops.
// ----------------------------------------------------------------------------
module battery_gauge_monitor_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // tick requests
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_charge_pin,
    input  logic [bgm_pkg::ADC_BITS-1:0]      s_adc_sample,
    input  logic                              s_adc_ok,
    // status results
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bgm_pkg::LEVEL_W-1:0]       m_level_percent,
    output logic [bgm_pkg::ADC_BITS-1:0]      m_window_average,
    output logic                              m_charging_shown,
    output logic                              m_discharging,
    output logic                              m_low_battery,
    output logic                              m_charge_changed,
    output logic                              m_low_changed,
    output logic                              m_sample_taken,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bgm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bgm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Configuration registers.
    logic [bgm_pkg::LEVEL_W-1:0]  threshold_reg;
    logic [bgm_pkg::TICK_W-1:0]   interval_reg;
    logic                         paused_reg;

    // Pipeline links between the stages.
    logic          win_valid, win_ready;
    bgm_pkg::win_t win_data;
    logic          avg_valid, avg_ready;
    bgm_pkg::avg_t avg_data;
    logic          lvl_valid, lvl_ready;
    bgm_pkg::lvl_t lvl_data;

    // Result stage state.
    logic                         m_valid_reg;
    logic                         low_flag_reg, low_flag_next;
    logic                         low_ev;
    logic                         new_low;
    logic                         load;

    logic [bgm_pkg::LEVEL_W-1:0]  level_out_reg;
    logic [bgm_pkg::ADC_BITS-1:0] avg_out_reg;
    logic                         charging_out_reg;
    logic                         charge_ev_out_reg;
    logic                         low_ev_out_reg;
    logic                         taken_out_reg;

    // The configuration port never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= bgm_pkg::THRESHOLD_RESET;
            interval_reg  <= bgm_pkg::INTERVAL_RESET;
            paused_reg    <= 1'b0;
        end else if (cfg_valid) begin
            unique case (bgm_pkg::cfg_index_t'(cfg_index))
                bgm_pkg::CFG_LOW_THRESHOLD: begin
                    threshold_reg <= cfg_data[bgm_pkg::LEVEL_W-1:0];
                end
                bgm_pkg::CFG_SAMPLE_INTERVAL: begin
                    interval_reg <= cfg_data[bgm_pkg::TICK_W-1:0];
                end
                bgm_pkg::CFG_SAMPLING_PAUSED: begin
                    paused_reg <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Stage one: sampling decision, window update and window sum.
    bgm_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_valid),
        .in_ready        (s_ready),
        .charge_pin      (s_charge_pin),
        .adc_sample      (s_adc_sample),
        .adc_ok          (s_adc_ok),
        .sample_interval (interval_reg),
        .sampling_paused (paused_reg),
        .out_valid       (win_valid),
        .out_ready       (win_ready),
        .out_data        (win_data)
    );

    // Stage two: truncated window average.
    bgm_avg u_avg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (win_valid),
        .in_ready  (win_ready),
        .in_data   (win_data),
        .out_valid (avg_valid),
        .out_ready (avg_ready),
        .out_data  (avg_data)
    );

    // Stage three: level in percent from the discharge curve.
    bgm_curve u_curve (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (avg_valid),
        .in_ready  (avg_ready),
        .in_data   (avg_data),
        .out_valid (lvl_valid),
        .out_ready (lvl_ready),
        .out_data  (lvl_data)
    );

    // Stage four: the low-battery flag is only re-evaluated once the window
    // is full and a sample has actually been taken on this tick.
    assign lvl_ready = !m_valid_reg || m_ready;
    assign load      = lvl_valid && lvl_ready;
    assign new_low   = (lvl_data.level <= threshold_reg);

    always_comb begin
        low_flag_next = low_flag_reg;
        low_ev        = 1'b0;
        if (lvl_data.flags.taken && lvl_data.flags.full) begin
            low_flag_next = new_low;
            low_ev        = (new_low != low_flag_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            low_flag_reg <= 1'b0;
        end else begin
            if (lvl_ready) begin
                m_valid_reg <= lvl_valid;
            end
            if (load) begin
                low_flag_reg <= low_flag_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            level_out_reg     <= lvl_data.level;
            avg_out_reg       <= lvl_data.avg;
            charging_out_reg  <= lvl_data.flags.charging;
            charge_ev_out_reg <= lvl_data.flags.charge_ev;
            low_ev_out_reg    <= low_ev;
            taken_out_reg     <= lvl_data.flags.taken;
        end
    end

    // The low flag register always matches the request held in the result
    // register, since it is written on the same edge.
    assign m_valid          = m_valid_reg;
    assign m_level_percent  = level_out_reg;
    assign m_window_average = avg_out_reg;
    assign m_charging_shown = charging_out_reg && (level_out_reg < bgm_pkg::LEVEL_FULL);
    assign m_discharging    = !charging_out_reg;
    assign m_low_battery    = low_flag_reg;
    assign m_charge_changed = charge_ev_out_reg;
    assign m_low_changed    = low_ev_out_reg;
    assign m_sample_taken   = taken_out_reg;

endmodule

FILE: rtl/bgm_ctrl.sv
// ----------------------------------------------------------------------------
// Battery gauge sampling control
// Decides per tick whether a sample is due, keeps the sample window and
// registers the window sum for the averaging stage.
// ----------------------------------------------------------------------------
module bgm_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          charge_pin,
    input  logic [bgm_pkg::ADC_BITS-1:0]  adc_sample,
    input  logic                          adc_ok,
    input  logic [bgm_pkg::TICK_W-1:0]    sample_interval,
    input  logic                          sampling_paused,
    output logic                          out_valid,
    input  logic                          out_ready,
    output bgm_pkg::win_t                 out_data
);

    logic                         started_reg, started_next;
    logic                         charging_reg, charging_next;
    logic [bgm_pkg::FILL_W-1:0]   fill_reg, fill_next;
    logic [bgm_pkg::TICK_W-1:0]   tick_reg, tick_next;
    logic [bgm_pkg::TICK_W-1:0]   tick_inc;
    logic [bgm_pkg::ADC_BITS-1:0] window_reg  [0:bgm_pkg::WINDOW_DEPTH-1];
    logic [bgm_pkg::ADC_BITS-1:0] window_next [0:bgm_pkg::WINDOW_DEPTH-1];
    logic                         valid_reg;
    bgm_pkg::win_t                data_reg, data_next;
    logic                         accept;
    logic                         pin_charging;
    logic                         due;
    logic                         charge_ev;
    logic                         taken;
    logic                         full_before;
    logic [bgm_pkg::SUM_W-1:0]    sum;

    assign in_ready     = !valid_reg || out_ready;
    assign accept       = in_valid && in_ready;
    assign pin_charging = !charge_pin;
    assign full_before  = (fill_reg == bgm_pkg::FILL_W'(bgm_pkg::WINDOW_DEPTH));
    assign tick_inc     = tick_reg + 1'b1;

    always_comb begin
        started_next  = started_reg;
        charging_next = charging_reg;
        tick_next     = tick_reg;
        due           = 1'b0;
        charge_ev     = 1'b0;
        if (!sampling_paused) begin
            if (!started_reg) begin
                started_next  = 1'b1;
                charging_next = pin_charging;
                due           = 1'b1;
            end else if (pin_charging != charging_reg) begin
                charging_next = pin_charging;
                charge_ev     = 1'b1;
                due           = 1'b1;
            end else if (!full_before) begin
                due = 1'b1;
            end else if (tick_inc >= sample_interval) begin
                tick_next = '0;
                due       = 1'b1;
            end else begin
                tick_next = tick_inc;
            end
        end
        taken = due && adc_ok;
    end

    // Window update: fill in order, then shift out the oldest entry.
    always_comb begin
        window_next = window_reg;
        fill_next   = fill_reg;
        if (taken) begin
            if (!full_before) begin
                for (int i = 0; i < bgm_pkg::WINDOW_DEPTH; i++) begin
                    if (fill_reg == bgm_pkg::FILL_W'(i)) begin
                        window_next[i] = adc_sample;
                    end
                end
                fill_next = fill_reg + 1'b1;
            end else begin
                for (int i = 0; i < bgm_pkg::WINDOW_DEPTH - 1; i++) begin
                    window_next[i] = window_reg[i + 1];
                end
                window_next[bgm_pkg::WINDOW_DEPTH - 1] = adc_sample;
            end
        end
    end

    always_comb begin
        sum = '0;
        for (int i = 0; i < bgm_pkg::WINDOW_DEPTH; i++) begin
            if (bgm_pkg::FILL_W'(i) < fill_next) begin
                sum = sum + bgm_pkg::SUM_W'(window_next[i]);
            end
        end
        data_next.flags.charging  = charging_next;
        data_next.flags.charge_ev = charge_ev;
        data_next.flags.taken     = taken;
        data_next.flags.full      = (fill_next == bgm_pkg::FILL_W'(bgm_pkg::WINDOW_DEPTH));
        data_next.fill            = fill_next;
        data_next.sum             = sum;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg  <= 1'b0;
            charging_reg <= 1'b0;
            fill_reg     <= '0;
            tick_reg     <= '0;
            valid_reg    <= 1'b0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (accept) begin
                started_reg  <= started_next;
                charging_reg <= charging_next;
                fill_reg     <= fill_next;
                tick_reg     <= tick_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            window_reg <= window_next;
            data_reg   <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/bgm_avg.sv
// ----------------------------------------------------------------------------
// Battery gauge window average
// Divides the window sum by the fill count through a reciprocal multiply.
// ----------------------------------------------------------------------------
module bgm_avg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  bgm_pkg::win_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output bgm_pkg::avg_t out_data
);

    localparam int PROD_W = bgm_pkg::SUM_W + bgm_pkg::RECIP_W;

    logic                         valid_reg;
    bgm_pkg::avg_t                data_reg, data_next;
    logic [bgm_pkg::RECIP_W-1:0]  recip;
    logic [PROD_W-1:0]            prod;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        recip = bgm_pkg::RECIP_TAB[bgm_pkg::RECIP_IDX_W'(in_data.fill)];
        prod  = PROD_W'(in_data.sum) * PROD_W'(recip);
        data_next.flags = in_data.flags;
        data_next.avg   = prod[bgm_pkg::RECIP_FRAC +: bgm_pkg::ADC_BITS];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/bgm_curve.sv
// ----------------------------------------------------------------------------
// Battery gauge level curve
// Maps the window average to a percent and holds the current level.
// ----------------------------------------------------------------------------
module bgm_curve (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  bgm_pkg::avg_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output bgm_pkg::lvl_t out_data
);

    logic                              valid_reg;
    logic [bgm_pkg::LEVEL_W-1:0]       level_reg, level_next;
    bgm_pkg::lvl_t                     data_reg, data_next;
    logic                              accept;
    logic [bgm_pkg::CURVE_W-1:0]       avg_ext;
    logic [bgm_pkg::SEG_W-1:0]         seg;
    logic [bgm_pkg::DELTA_W-1:0]       delta;
    logic [bgm_pkg::CURVE_PROD_W-1:0]  prod;
    logic [bgm_pkg::LEVEL_W-1:0]       curve_level;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign avg_ext  = bgm_pkg::CURVE_W'(in_data.avg);

    always_comb begin
        seg = '0;
        for (int i = 1; i < bgm_pkg::CURVE_POINTS - 1; i++) begin
            if (avg_ext >= bgm_pkg::CURVE_ADC[i]) begin
                seg = bgm_pkg::SEG_W'(i);
            end
        end
        delta = bgm_pkg::DELTA_W'(avg_ext - bgm_pkg::CURVE_ADC[seg]);
        prod  = bgm_pkg::CURVE_PROD_W'(delta) * bgm_pkg::CURVE_PROD_W'(bgm_pkg::CURVE_SLOPE[seg]);
        if (avg_ext < bgm_pkg::CURVE_ADC[0]) begin
            curve_level = bgm_pkg::LEVEL_EMPTY;
        end else if (avg_ext >= bgm_pkg::CURVE_ADC[bgm_pkg::CURVE_POINTS - 1]) begin
            curve_level = bgm_pkg::LEVEL_FULL;
        end else begin
            curve_level = bgm_pkg::CURVE_PCT[seg]
                        + bgm_pkg::LEVEL_W'(prod >> bgm_pkg::SLOPE_FRAC);
        end
    end

    always_comb begin
        level_next = level_reg;
        if (in_data.flags.taken) begin
            level_next = curve_level;
        end
        data_next.flags = in_data.flags;
        data_next.avg   = in_data.avg;
        data_next.level = level_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            level_reg <= bgm_pkg::LEVEL_RESET;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (accept) begin
                level_reg <= level_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: dv/battery_gauge_monitor_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Battery gauge monitor testbench
// Drives check ticks and register writes into the gauge and checks every
// status result against a cycle-free gauge model in the bench or a result typed by hand.
// ----------------------------------------------------------------------------
// A short directed plan goes first. It covers the paused block straight
// after reset, the first tick, failed reads, charge changes, the zero, small
// and largest sample intervals, and thresholds of zero, 100 and above range.
// Random ticks follow in chunks, each under fresh register settings and with
// idling on one side, the other, or neither. Two long stalls of the result
// side let the pipeline fill so that s_ready has to drop.
// ----------------------------------------------------------------------------
module battery_gauge_monitor_unit_test;

    localparam int HALF_PERIOD  = 2;
    localparam int DEPTH        = bgm_pkg::WINDOW_DEPTH;
    localparam int ADC_W        = bgm_pkg::ADC_BITS;
    localparam int LVL_W        = bgm_pkg::LEVEL_W;
    localparam int SETTLE_EDGES = 8;
    localparam int HOLD_CYCLES  = 64;
    localparam int CHUNKS       = 10;
    localparam int CHUNK_TICKS  = 50;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int REPORT_LIMIT = 10;

    // One status result as the block presents it.
    typedef struct packed {
        logic [LVL_W-1:0]    level;
        logic [ADC_W-1:0]    average;
        logic                charging_shown;
        logic                discharging;
        logic                low_battery;
        logic                charge_changed;
        logic                low_changed;
        logic                sample_taken;
    } gauge_status_t;

    // One row of the directed plan: either a register write or a tick, the
    // latter optionally with a result typed in by hand.
    typedef struct packed {
        logic                 is_write;
        bgm_pkg::cfg_index_t  reg_idx;
        logic [7:0]           reg_data;
        logic                 pin;
        logic [ADC_W-1:0]     adc;
        logic                 ok;
        logic                 has_known;
        gauge_status_t        known;
    } plan_row_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic                           s_charge_pin = 1'b1;
    logic [ADC_W-1:0]               s_adc_sample = '0;
    logic                           s_adc_ok = 1'b0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [LVL_W-1:0]               m_level_percent;
    logic [ADC_W-1:0]               m_window_average;
    logic                           m_charging_shown;
    logic                           m_discharging;
    logic                           m_low_battery;
    logic                           m_charge_changed;
    logic                           m_low_changed;
    logic                           m_sample_taken;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [bgm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [bgm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Gauge model: register copies and the state that the ticks move.
    logic [LVL_W-1:0]    threshold_cfg = bgm_pkg::THRESHOLD_RESET;
    logic [7:0]          interval_cfg = bgm_pkg::INTERVAL_RESET;
    logic                paused_cfg = 1'b0;
    logic                started = 1'b0;
    logic                charging = 1'b0;
    logic                low = 1'b0;
    logic [LVL_W-1:0]    level = bgm_pkg::LEVEL_RESET;
    logic [ADC_W-1:0]    window [DEPTH];
    int                  fill = 0;
    logic [7:0]          ticks = '0;

    // Knots of the discharge curve: converter reading against percent.
    int knot_adc [0:6] = '{1650, 1750, 1825, 1900, 1975, 2050, 2100};
    int knot_pct [0:6] = '{0, 10, 20, 40, 60, 80, 100};

    // Directed plan, walked in order.
    plan_row_t plan [$];

    // Results still owed by the block, oldest first.
    gauge_status_t pending_status [$];

    int fault_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int holds_asked = 0;
    int holds_served = 0;
    int hold_left = 0;

    battery_gauge_monitor_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_charge_pin     (s_charge_pin),
        .s_adc_sample     (s_adc_sample),
        .s_adc_ok         (s_adc_ok),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_level_percent  (m_level_percent),
        .m_window_average (m_window_average),
        .m_charging_shown (m_charging_shown),
        .m_discharging    (m_discharging),
        .m_low_battery    (m_low_battery),
        .m_charge_changed (m_charge_changed),
        .m_low_changed    (m_low_changed),
        .m_sample_taken   (m_sample_taken),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always begin
        #(HALF_PERIOD) aclk = 1'b1;
        #(HALF_PERIOD) aclk = 1'b0;
    end

    // Advances the gauge model by one tick and returns the status it shows.
    // Unless paused, a charge change or the very first tick forces a sample;
    // otherwise a sample is due while the window fills, and then once per interval.
    function automatic gauge_status_t gauge_tick(logic pin, logic [ADC_W-1:0] adc,
                                                 logic ok);
        gauge_status_t st;
        logic          now_charging;
        logic          due;
        int            sum;
        int            mean;
        int            seg;
        int            k;
        st = '0;
        now_charging = (pin == 1'b0);
        due = 1'b0;
        if (!paused_cfg) begin
            if (!started) begin
                // The first tick takes the charge state quietly.
                started = 1'b1;
                charging = now_charging;
                due = 1'b1;
            end else if (now_charging != charging) begin
                charging = now_charging;
                st.charge_changed = 1'b1;
                due = 1'b1;
            end else if (fill < DEPTH) begin
                due = 1'b1;
            end else begin
                ticks = ticks + 8'd1;
                if (ticks >= interval_cfg) begin
                    ticks = '0;
                    due = 1'b1;
                end
            end
            // A failed read leaves the window, the level and the low flag alone.
            if (due && ok) begin
                if (fill < DEPTH) begin
                    window[fill] = adc;
                    fill++;
                end else begin
                    for (k = 0; k < DEPTH - 1; k++)
                        window[k] = window[k + 1];
                    window[DEPTH - 1] = adc;
                end
                st.sample_taken = 1'b1;
            end
        end
        sum = 0;
        for (k = 0; k < fill; k++)
            sum += window[k];
        mean = (fill == 0) ? 0 : sum / fill;
        if (st.sample_taken) begin
            if (mean < knot_adc[0]) begin
                level = bgm_pkg::LEVEL_EMPTY;
            end else if (mean >= knot_adc[6]) begin
                level = bgm_pkg::LEVEL_FULL;
            end else begin
                seg = 0;
                while (mean >= knot_adc[seg + 1])
                    seg++;
                level = LVL_W'(knot_pct[seg] + (mean - knot_adc[seg]) *
                        (knot_pct[seg + 1] - knot_pct[seg]) /
                        (knot_adc[seg + 1] - knot_adc[seg]));
            end
            // The low flag only follows the level once the window is full.
            if (fill == DEPTH && ((level <= threshold_cfg) != low)) begin
                low = !low;
                st.low_changed = 1'b1;
            end
        end
        st.level = level;
        st.average = ADC_W'(mean);
        st.charging_shown = charging && (level < bgm_pkg::LEVEL_FULL);
        st.discharging = !charging;
        st.low_battery = low;
        return st;
    endfunction

    function automatic plan_row_t tick_row(logic pin, logic [ADC_W-1:0] adc, logic ok,
                                           logic has_known = 1'b0,
                                           gauge_status_t known = '0);
        plan_row_t r;
        r = '0;
        r.pin = pin;
        r.adc = adc;
        r.ok = ok;
        r.has_known = has_known;
        r.known = known;
        return r;
    endfunction

    function automatic plan_row_t write_row(bgm_pkg::cfg_index_t idx, logic [7:0] data);
        plan_row_t r;
        r = '0;
        r.is_write = 1'b1;
        r.reg_idx = idx;
        r.reg_data = data;
        return r;
    endfunction

    // Appends one row to the end of the directed plan.
    function automatic void add_row(plan_row_t r);
        plan.insert(plan.size(), r);
    endfunction

    // Stops offering ticks, waits until every owed result has arrived and then
    // waits on further so that nothing is left in flight.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_EDGES) @(posedge aclk);
    endtask

    // Register writes only happen with the block idle, so each one settles
    // first; the settling also keeps the lowering and raising of cfg_valid
    // apart in time.
    task automatic write_reg(bgm_pkg::cfg_index_t idx, logic [7:0] data);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            bgm_pkg::CFG_LOW_THRESHOLD:   threshold_cfg = data[LVL_W-1:0];
            bgm_pkg::CFG_SAMPLE_INTERVAL: interval_cfg = data;
            bgm_pkg::CFG_SAMPLING_PAUSED: paused_cfg = data[0];
            default: ;
        endcase
    endtask

    // Offers one tick request. Valid is lowered only for an idle gap, so a
    // request that follows straight on keeps valid high across the edge.
    task automatic send_tick(logic pin, logic [ADC_W-1:0] adc, logic ok,
                             logic has_known = 1'b0, gauge_status_t known = '0);
        gauge_status_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_charge_pin <= pin;
        s_adc_sample <= adc;
        s_adc_ok <= ok;
        do @(posedge aclk); while (!s_ready);
        predicted = gauge_tick(pin, adc, ok);
        pending_status.insert(pending_status.size(), has_known ? known : predicted);
    endtask

    // Result side: random back-pressure, or a long stall whenever the
    // stimulus asks for one, counted down here edge by edge.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (holds_asked != holds_served) begin
            holds_served = holds_served + 1;
            hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Every accepted result is checked against the oldest owed one.
    always @(posedge aclk) begin
        gauge_status_t seen;
        gauge_status_t want;
        if (aresetn && m_valid && m_ready) begin
            seen = '{m_level_percent, m_window_average, m_charging_shown, m_discharging,
                     m_low_battery, m_charge_changed, m_low_changed, m_sample_taken};
            if (pending_status.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("unexpected result: level %0d avg %0d flags %b", seen.level,
                             seen.average, seen[5:0]);
            end else begin
                want = pending_status.pop_front();
                if (seen.level !== want.level || seen.average !== want.average ||
                    seen.charging_shown !== want.charging_shown ||
                    seen.discharging !== want.discharging ||
                    seen.low_battery !== want.low_battery ||
                    seen.charge_changed !== want.charge_changed ||
                    seen.low_changed !== want.low_changed ||
                    seen.sample_taken !== want.sample_taken) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("mismatch: expected level %0d avg %0d flags %b, %s %0d %s %0d %s %b",
                                 want.level, want.average, want[5:0], "got level",
                                 seen.level, "avg", seen.average, "flags", seen[5:0]);
                end
            end
        end
    end

    // Watchdog: a run that hangs ends here.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        plan_row_t        row;
        logic             pin_now;
        logic [ADC_W-1:0] adc;
        logic             ok;
        int               n;
        int               c;
        int               pick;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 24;
        recv_idle_pct <= 87;

        // Paused straight after reset: even the first tick is ignored and the
        // reset status comes back.
        add_row(write_row(bgm_pkg::CFG_SAMPLING_PAUSED, 8'd1));
        add_row(tick_row(1'b0, 12'd2000, 1'b1, 1'b1,
                         gauge_status_t'{7'd80, 12'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}));
        add_row(write_row(bgm_pkg::CFG_SAMPLING_PAUSED, 8'd0));
        // First tick: charge state taken without an event, full-scale sample.
        add_row(tick_row(1'b1, 12'd4095, 1'b1, 1'b1,
                         gauge_status_t'{7'd100, 12'd4095, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}));
        add_row(tick_row(1'b1, 12'd0, 1'b1));
        // Failed read while the window fills.
        add_row(tick_row(1'b1, 12'hABC, 1'b0));
        // Window becomes full; the low flag is decided for the first time.
        add_row(tick_row(1'b1, 12'd0, 1'b1));
        // Charge change forces a sample.
        add_row(tick_row(1'b0, 12'd2100, 1'b1));
        add_row(tick_row(1'b0, 12'd1650, 1'b1));
        // Charge change with a failed read: event still shown, no sample.
        add_row(tick_row(1'b1, 12'd2000, 1'b0));
        // Zero interval: a sample on every tick.
        add_row(write_row(bgm_pkg::CFG_SAMPLE_INTERVAL, 8'd0));
        add_row(tick_row(1'b1, 12'd4095, 1'b1));
        add_row(tick_row(1'b1, 12'd4095, 1'b1));
        add_row(tick_row(1'b1, 12'd4095, 1'b1, 1'b1,
                         gauge_status_t'{7'd100, 12'd4095, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}));
        // Threshold above range: even a full battery reads as low.
        add_row(write_row(bgm_pkg::CFG_LOW_THRESHOLD, 8'd127));
        add_row(tick_row(1'b1, 12'd4095, 1'b1, 1'b1,
                         gauge_status_t'{7'd100, 12'd4095, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1}));
        add_row(write_row(bgm_pkg::CFG_LOW_THRESHOLD, 8'd0));
        add_row(write_row(bgm_pkg::CFG_SAMPLE_INTERVAL, 8'd2));
        add_row(tick_row(1'b0, 12'd1649, 1'b1));
        add_row(tick_row(1'b0, 12'd1649, 1'b1));
        // Sample due on the interval but the read fails.
        add_row(tick_row(1'b0, 12'd1649, 1'b0));
        add_row(tick_row(1'b0, 12'd1649, 1'b1));
        add_row(tick_row(1'b0, 12'd1649, 1'b1));
        add_row(write_row(bgm_pkg::CFG_SAMPLE_INTERVAL, 8'd255));
        add_row(tick_row(1'b0, 12'd0, 1'b1));
        // Paused mid-run: a pin change is neither taken nor reported.
        add_row(write_row(bgm_pkg::CFG_SAMPLING_PAUSED, 8'd1));
        add_row(tick_row(1'b1, 12'd4095, 1'b1));
        add_row(tick_row(1'b1, 12'd0, 1'b0));
        add_row(write_row(bgm_pkg::CFG_SAMPLING_PAUSED, 8'd0));
        add_row(write_row(bgm_pkg::CFG_LOW_THRESHOLD, 8'd100));
        add_row(tick_row(1'b1, 12'd1650, 1'b1));
        add_row(tick_row(1'b0, 12'd2099, 1'b1));
        add_row(tick_row(1'b1, 12'd2050, 1'b1));
        add_row(write_row(bgm_pkg::CFG_LOW_THRESHOLD, 8'd15));
        add_row(write_row(bgm_pkg::CFG_SAMPLE_INTERVAL, 8'd1));
        add_row(tick_row(1'b1, 12'd1900, 1'b1));
        add_row(tick_row(1'b1, 12'd1825, 1'b1));

        for (n = 0; n < plan.size(); n++) begin
            row = plan[n];
            if (row.is_write)
                write_reg(row.reg_idx, row.reg_data);
            else
                send_tick(row.pin, row.adc, row.ok, row.has_known, row.known);
        end

        // Random chunks. Most readings fall on the curve so that levels move
        // through every segment; the rest are anywhere in range or at the
        // knot edges. Short intervals keep samples coming once a window is
        // full.
        pin_now = 1'b1;
        for (c = 0; c < CHUNKS; c++) begin
            pick = $urandom_range(9);
            write_reg(bgm_pkg::CFG_LOW_THRESHOLD,
                      (pick == 0) ? 8'd0 : (pick == 1) ? 8'd100 :
                      (pick == 2) ? 8'd127 : 8'($urandom_range(100)));
            pick = $urandom_range(9);
            write_reg(bgm_pkg::CFG_SAMPLE_INTERVAL,
                      (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 :
                      (pick == 2) ? 8'($urandom_range(255)) :
                      8'($urandom_range(4, 1)));
            write_reg(bgm_pkg::CFG_SAMPLING_PAUSED, 8'd0);
            if (c < 4) begin
                send_idle_pct = 24;
                recv_idle_pct <= 87;
            end else if (c < 7) begin
                send_idle_pct = 87;
                recv_idle_pct <= 24;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            // With no idling on either side, a long stall on the result side
            // lets the pipeline fill while requests keep coming.
            if (c == 7 || c == 9)
                holds_asked <= holds_asked + 1;
            for (n = 0; n < CHUNK_TICKS; n++) begin
                if ($urandom_range(99) < 8)
                    pin_now = !pin_now;
                pick = $urandom_range(9);
                if (pick < 8)
                    adc = ADC_W'($urandom_range(2150, 1600));
                else if (pick == 8)
                    adc = ADC_W'($urandom_range(4095));
                else
                    case ($urandom_range(5))
                        0: adc = 12'd0;
                        1: adc = 12'd4095;
                        2: adc = 12'd1649;
                        3: adc = 12'd1650;
                        4: adc = 12'd2099;
                        default: adc = 12'd2100;
                    endcase
                ok = ($urandom_range(9) != 0);
                send_tick(pin_now, adc, ok);
            end
        end

        settle();
        if (fault_count == 0 && pending_status.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: files.f
rtl/bgm_pkg.sv
rtl/bgm_ctrl.sv
rtl/bgm_avg.sv
rtl/bgm_curve.sv
rtl/battery_gauge_monitor_unit.sv
dv/battery_gauge_monitor_unit_test.sv
